// ===== hw/rtl/slot_region_allocator_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the slot region allocator core.
// ---------------------------------------------------------------------------
`ifndef SLOT_REGION_ALLOCATOR_CORE_MACROS_SVH
`define SLOT_REGION_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define SRA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SRA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/slra_pkg.sv =====
// ---------------------------------------------------------------------------
// slra_pkg
// Sizes, codes and the region table entry type of the slot region allocator.
// ---------------------------------------------------------------------------
package slra_pkg;

  localparam int SLOTS_PER_BUFFER = 256;
  localparam int MAX_BUFFERS      = 16;
  localparam int MAX_REGIONS      = 64;

  // Field widths of the item and result.
  localparam int BUF_W    = 4;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;

  localparam int ADDR_W = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int LEN_W  = $clog2(SLOTS_PER_BUFFER + 1);
  localparam int OPEN_W = $clog2(MAX_BUFFERS + 1);
  localparam int SUM_W  = LEN_W + 1;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_BUFFER  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic [BUF_W-1:0]  buffer;
    logic [SLOT_W-1:0] start;
    logic [LEN_W-1:0]  length;
  } region_t;

  localparam int REGION_W = $bits(region_t);

endpackage

// ===== hw/rtl/slra_ram.sv =====
// ---------------------------------------------------------------------------
// slra_ram
// Generic RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module slra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/slot_region_allocator_core.sv =====
// ---------------------------------------------------------------------------
// slot_region_allocator_core
// Grants and frees single slots in a set of equal buffers, keeping free slots
// as a stack-ordered table of regions held in one RAM.
// ---------------------------------------------------------------------------
//
//   channel  handshake          payload
//   in       start, busy        in_opcode, in_release_buffer, in_release_slot
//   out      out_valid strobe   out_status, out_granted_buffer, out_granted_slot
//
// An acquire reads the top region from RAM and takes a slot from it, unless the
// table is empty, when a fresh buffer is opened. A release into a non-empty table
// scans it from entry 0; the scan reads the region RAM one entry a cycle.
// Synchronous reset empties the table and closes all buffers; no clearing pass.
// The result strobe lasts one cycle and cannot be held off by the receiver.
//
module slot_region_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [slra_pkg::BUF_W-1:0]     in_release_buffer,
  input  logic [slra_pkg::SLOT_W-1:0]    in_release_slot,
  output logic                           out_valid,
  output logic [slra_pkg::STATUS_W-1:0]  out_status,
  output logic [slra_pkg::BUF_W-1:0]     out_granted_buffer,
  output logic [slra_pkg::SLOT_W-1:0]    out_granted_slot
);

  import slra_pkg::*;

`include "slot_region_allocator_core_macros.svh"

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ACQ      = 6'b000010,
    ST_ACQ_UPD  = 6'b000100,
    ST_REL      = 6'b001000,
    ST_REL_SCAN = 6'b010000,
    ST_SPARE    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [OPEN_W-1:0] opened_r, opened_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              op_r, op_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic                valid_r, valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BUF_W-1:0]    gbuf_r, gbuf_nxt;
  logic [SLOT_W-1:0]   gslot_r, gslot_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  region_t           ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REGION_W-1:0] ram_rdata;
  region_t           rd;

  logic              accept;
  logic              out_of_range;
  logic              front_hit;
  logic              back_hit;
  logic [SUM_W-1:0]  region_end;

  slra_ram #(
    .WIDTH(REGION_W),
    .DEPTH(MAX_REGIONS)
  ) u_region_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd     = region_t'(ram_rdata);
  assign accept = start && (state_r == ST_IDLE);

  assign out_of_range = (OPEN_W'(buf_r) >= opened_r) || (32'(slot_r) >= SLOTS_PER_BUFFER);
  assign region_end   = SUM_W'(rd.start) + SUM_W'(rd.length);
  assign front_hit    = (rd.buffer == buf_r) &&
                        ((SUM_W'(rd.start)) == (SUM_W'(slot_r) + SUM_W'(1)));
  assign back_hit     = (rd.buffer == buf_r) && (SUM_W'(slot_r) == region_end);

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    opened_nxt = opened_r;
    idx_nxt    = idx_r;
    op_nxt     = op_r;
    buf_nxt    = buf_r;
    slot_nxt   = slot_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    gbuf_nxt   = gbuf_r;
    gslot_nxt  = gslot_r;
    ram_we     = 1'b0;
    ram_waddr  = total_r[ADDR_W-1:0];
    ram_wdata  = '{buffer: buf_r, start: slot_r, length: LEN_W'(1)};
    ram_raddr  = ADDR_W'(total_r - CNT_W'(1));

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          buf_nxt   = in_release_buffer;
          slot_nxt  = in_release_slot;
          state_nxt = (in_opcode == OP_ACQUIRE) ? ST_ACQ : ST_REL;
        end
      end

      ST_ACQ: begin
        if (total_r == '0) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
          if (opened_r >= OPEN_W'(MAX_BUFFERS)) begin
            status_nxt = STATUS_NO_BUFFER;
            gbuf_nxt   = '0;
            gslot_nxt  = '0;
          end else begin
            // Open a fresh buffer and grant its first slot in one go.
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = '{buffer: opened_r[BUF_W-1:0], start: SLOT_W'(1),
                           length: LEN_W'(SLOTS_PER_BUFFER - 1)};
            total_nxt  = (SLOTS_PER_BUFFER > 1) ? CNT_W'(1) : CNT_W'(0);
            opened_nxt = opened_r + OPEN_W'(1);
            status_nxt = STATUS_OK;
            gbuf_nxt   = opened_r[BUF_W-1:0];
            gslot_nxt  = '0;
          end
        end else begin
          state_nxt = ST_ACQ_UPD;
        end
      end

      ST_ACQ_UPD: begin
        ram_we     = 1'b1;
        ram_waddr  = ADDR_W'(total_r - CNT_W'(1));
        ram_wdata  = '{buffer: rd.buffer, start: rd.start + SLOT_W'(1),
                       length: rd.length - LEN_W'(1)};
        if (rd.length == LEN_W'(1)) begin
          total_nxt = total_r - CNT_W'(1);
        end
        state_nxt  = ST_IDLE;
        valid_nxt  = 1'b1;
        status_nxt = STATUS_OK;
        gbuf_nxt   = rd.buffer;
        gslot_nxt  = rd.start;
      end

      ST_REL: begin
        status_nxt = STATUS_OK;
        gbuf_nxt   = '0;
        gslot_nxt  = '0;
        ram_raddr  = '0;
        idx_nxt    = '0;
        if (out_of_range) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
        end else if (total_r == '0) begin
          ram_we    = 1'b1;
          total_nxt = total_r + CNT_W'(1);
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_REL_SCAN;
        end
      end

      ST_REL_SCAN: begin
        // The RAM output belongs to entry idx_r; the next entry is fetched now.
        ram_raddr = ADDR_W'(idx_r + CNT_W'(1));
        ram_waddr = idx_r[ADDR_W-1:0];
        if (front_hit) begin
          ram_we    = 1'b1;
          ram_wdata = '{buffer: rd.buffer, start: slot_r, length: rd.length + LEN_W'(1)};
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
        end else if (back_hit) begin
          ram_we    = 1'b1;
          ram_wdata = '{buffer: rd.buffer, start: rd.start, length: rd.length + LEN_W'(1)};
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
        end else if (idx_r == total_r - CNT_W'(1)) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
          if (total_r >= CNT_W'(MAX_REGIONS)) begin
            status_nxt = STATUS_TABLE_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = total_r[ADDR_W-1:0];
            ram_wdata = '{buffer: buf_r, start: slot_r, length: LEN_W'(1)};
            total_nxt = total_r + CNT_W'(1);
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      total_r  <= '0;
      opened_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      opened_r <= opened_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    op_r     <= op_nxt;
    buf_r    <= buf_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    gbuf_r   <= gbuf_nxt;
    gslot_r  <= gslot_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_granted_buffer = gbuf_r;
  assign out_granted_slot   = gslot_r;

  `SRA_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, accept, busy)
  `SRA_ASSERT_SAME(a_strobe_when_idle, clk, rst_n, out_valid, state_r == ST_IDLE)
  `SRA_ASSERT_SAME(a_failed_grants_zero, clk, rst_n, out_valid && (out_status != STATUS_OK),
                   (out_granted_buffer == '0) && (out_granted_slot == '0))
  `SRA_ASSERT_SAME(a_counts_bounded, clk, rst_n, 1'b1,
                   (total_r <= CNT_W'(MAX_REGIONS)) && (opened_r <= OPEN_W'(MAX_BUFFERS)))
  `SRA_ASSERT_NEXT(a_op_matches_path, clk, rst_n, state_r == ST_ACQ_UPD,
                   (op_r == OP_ACQUIRE) && out_valid)

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot region allocator core testbench
// Sends acquire and release items through the start/busy handshake and checks
// every strobed result against a predictor that keeps its own copy of the free
// region table. Covers directed corner cases, random traffic under several
// sender idle rates, exhaustion of every buffer, and a full region table.
// ---------------------------------------------------------------------------
module testbench;
  import slra_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 2 * MAX_REGIONS + 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUF_W-1:0]    buffer;
    logic [SLOT_W-1:0]   slot;
  } grant_t;

  typedef struct packed {
    logic [BUF_W-1:0]  buffer;
    logic [SLOT_W-1:0] slot;
  } slot_ref_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_opcode;
  logic [BUF_W-1:0]    in_release_buffer;
  logic [SLOT_W-1:0]   in_release_slot;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [BUF_W-1:0]    out_granted_buffer;
  logic [SLOT_W-1:0]   out_granted_slot;

  slot_region_allocator_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_release_buffer  (in_release_buffer),
    .in_release_slot    (in_release_slot),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_buffer (out_granted_buffer),
    .out_granted_slot   (out_granted_slot)
  );

  // Predicted free region table, kept as a stack.
  int free_buffer [MAX_REGIONS];
  int free_start  [MAX_REGIONS];
  int free_length [MAX_REGIONS];
  int free_count;
  int opened_buffers;

  grant_t    pending_grants [$];
  slot_ref_t held_slots [$];

  int error_count;
  int cycle_count;
  int sender_idle_pct;
  int acquire_count;
  int release_count;
  int no_buffer_count;
  int table_full_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic grant_t predict_grant(logic op, logic [BUF_W-1:0] buf_idx,
                                           logic [SLOT_W-1:0] slot_idx);
    grant_t g;
    int     top;
    int     b;
    int     s;
    g = '0;
    g.status = STATUS_OK;
    if (op == OP_ACQUIRE) begin
      if (free_count == 0) begin
        if (opened_buffers >= MAX_BUFFERS) begin
          g.status = STATUS_NO_BUFFER;
          return g;
        end
        free_buffer[0] = opened_buffers;
        free_start[0]  = 0;
        free_length[0] = SLOTS_PER_BUFFER;
        free_count     = 1;
        opened_buffers++;
      end
      top = free_count - 1;
      g.buffer = BUF_W'(free_buffer[top]);
      g.slot   = SLOT_W'(free_start[top]);
      free_start[top]++;
      free_length[top]--;
      if (free_length[top] == 0) free_count--;
      return g;
    end
    b = buf_idx;
    s = slot_idx;
    // Releases into a buffer that was never opened are dropped silently.
    if (b >= opened_buffers || s >= SLOTS_PER_BUFFER) return g;
    for (int i = 0; i < free_count; i++) begin
      if (free_buffer[i] == b) begin
        if (free_start[i] == s + 1) begin
          free_start[i] = s;
          free_length[i]++;
          return g;
        end
        if (s == free_start[i] + free_length[i]) begin
          free_length[i]++;
          return g;
        end
      end
    end
    if (free_count >= MAX_REGIONS) begin
      g.status = STATUS_TABLE_FULL;
      return g;
    end
    free_buffer[free_count] = b;
    free_start[free_count]  = s;
    free_length[free_count] = 1;
    free_count++;
    return g;
  endfunction

  function automatic void note_grant(grant_t g);
    pending_grants.insert(pending_grants.size(), g);
  endfunction

  function automatic void note_held(logic [BUF_W-1:0] b, logic [SLOT_W-1:0] s);
    slot_ref_t r;
    r.buffer = b;
    r.slot   = s;
    held_slots.insert(held_slots.size(), r);
  endfunction

  task automatic send_item(input logic op, input logic [BUF_W-1:0] b,
                           input logic [SLOT_W-1:0] s);
    grant_t g;
    @(negedge clk);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      // Mostly short gaps, now and then one long enough to span a release scan.
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 80)) @(negedge clk);
      else repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start             = 1'b1;
    in_opcode         = op;
    in_release_buffer = b;
    in_release_slot   = s;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = predict_grant(op, b, s);
    note_grant(g);
    if (op == OP_ACQUIRE) begin
      acquire_count++;
      if (g.status == STATUS_OK) note_held(g.buffer, g.slot);
      if (g.status == STATUS_NO_BUFFER) no_buffer_count++;
    end else begin
      release_count++;
      if (g.status == STATUS_TABLE_FULL) table_full_count++;
    end
  endtask

  task automatic acquire_slot();
    send_item(OP_ACQUIRE, BUF_W'($urandom_range(15)), SLOT_W'($urandom_range(255)));
  endtask

  task automatic release_slot(input int b, input int s);
    send_item(OP_RELEASE, BUF_W'(b), SLOT_W'(s));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        $error("result with no item pending: status %0d buffer %0d slot %0d",
               out_status, out_granted_buffer, out_granted_slot);
        error_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_granted_buffer !== want.buffer) begin
          $error("granted_buffer: expected %0d, got %0d", want.buffer, out_granted_buffer);
          error_count++;
        end
        if (out_granted_slot !== want.slot) begin
          $error("granted_slot: expected %0d, got %0d", want.slot, out_granted_slot);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[slot_region_allocator_core] ERROR");
      $finish;
    end
  end

  // Growth at both ends, one-slot pushes, dropped and double releases.
  task automatic test_directed();
    sender_idle_pct = 0;
    release_slot(0, 5);
    acquire_slot();
    acquire_slot();
    acquire_slot();
    acquire_slot();
    release_slot(0, 3);
    acquire_slot();
    release_slot(0, 1);
    acquire_slot();
    release_slot(0, 0);
    release_slot(0, 1);
    acquire_slot();
    acquire_slot();
    release_slot(1, 0);
    release_slot(15, 255);
    release_slot(0, 2);
    release_slot(0, 2);
    acquire_slot();
    acquire_slot();
    release_slot(0, 255);
    acquire_slot();
    wait_for_results();
  endtask

  // Mostly acquires, then releases of slots actually held, with some stray releases mixed in.
  task automatic test_random(input int idle_pct, input int n);
    int        r;
    int        idx;
    slot_ref_t pick;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (i == n / 2) wait_for_results();
      if (r < 55 || (r < 88 && held_slots.size() == 0)) begin
        acquire_slot();
      end else if (r < 88) begin
        idx  = $urandom_range(held_slots.size() - 1);
        pick = held_slots[idx];
        held_slots.delete(idx);
        release_slot(pick.buffer, pick.slot);
      end else begin
        release_slot($urandom_range(15), $urandom_range(255));
      end
    end
  endtask

  // Acquire until every buffer is open and nothing is free, then past that.
  task automatic test_exhaust();
    sender_idle_pct = 0;
    while (!(opened_buffers == MAX_BUFFERS && free_count == 0)) acquire_slot();
    acquire_slot();
    acquire_slot();
    wait_for_results();
  endtask

  // Fill the table with separate one-slot regions, then release more slots, new and adjacent.
  task automatic test_table_full();
    sender_idle_pct = 0;
    for (int i = 0; i < MAX_REGIONS; i++) release_slot(0, 2 * i);
    release_slot(0, 200);
    release_slot(0, 1);
    release_slot(0, 250);
    release_slot(0, 2 * MAX_REGIONS - 1);
    acquire_slot();
    acquire_slot();
    acquire_slot();
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_opcode         = OP_ACQUIRE;
    in_release_buffer = '0;
    in_release_slot   = '0;
    free_count        = 0;
    opened_buffers    = 0;
    error_count       = 0;
    cycle_count       = 0;
    sender_idle_pct   = 0;
    acquire_count     = 0;
    release_count     = 0;
    no_buffer_count   = 0;
    table_full_count  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(35, 250);
    test_random(66, 250);
    test_random(0, 250);
    test_exhaust();
    test_table_full();

    @(negedge clk);
    start = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d acquire and %0d release items over %0d buffers.",
             acquire_count, release_count, opened_buffers);
    $display("Acquires with every buffer used: %0d; releases into a full table: %0d.",
             no_buffer_count, table_full_count);
    if (error_count == 0) begin
      $display("[slot_region_allocator_core] OK");
    end else begin
      $display("[slot_region_allocator_core] ERROR");
    end
    $finish;
  end

endmodule
